### hw/rtl/lap3_pkg.sv
// ----------------------------------------------------------------------------
// lap3_pkg: shared definitions of the 3x3 Laplacian filter
// Field widths, register indexes, reset values and the position record that
// travels with every result item through the pipeline.
// ----------------------------------------------------------------------------
package lap3_pkg;

   // Default capacity of each line store, in pixels.
   localparam int MAX_WIDTH_DEF = 1024;

   // Fixed field widths.
   localparam int PIXEL_W     = 8;
   localparam int EDGE_W      = 12;
   localparam int ROW_W       = 16;
   localparam int IMG_W_W     = 11;
   localparam int IMG_H_W     = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   // Register reset values.
   localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 16'd480;

   // Smallest image side that the filter accepts.
   localparam int MIN_SIZE = 3;

   // Entries of the result queue.
   localparam int OUT_DEPTH = 8;

   // Row position and end-of-frame mark of one result item.
   typedef struct packed {
      logic             last;
      logic [ROW_W-1:0] centre_y;
   } pos_type;

endpackage

### hw/rtl/lap3_line_store.sv
// ----------------------------------------------------------------------------
// lap3_line_store: paired line store of the 3x3 Laplacian filter
// One synchronous memory holds the row two above and the row one above for
// every column. Reads are registered; a write to the address
// being read in the same cycle is forwarded to the read data.
// ----------------------------------------------------------------------------
module lap3_line_store #(
   parameter int DEPTH = lap3_pkg::MAX_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            rd_en,
   input  logic [$clog2(DEPTH)-1:0]        rd_addr,
   output logic [2*lap3_pkg::PIXEL_W-1:0]  rd_data,
   input  logic                            wr_en,
   input  logic [$clog2(DEPTH)-1:0]        wr_addr,
   input  logic [2*lap3_pkg::PIXEL_W-1:0]  wr_data
);
   import lap3_pkg::*;

   localparam int DW = 2 * PIXEL_W;

   logic [DW-1:0] store_mem [DEPTH];
   logic [DW-1:0] rd_q_ff;
   logic          fwd_hit_ff;
   logic [DW-1:0] fwd_data_ff;

   // Memory port: write first in program order, read returns the old entry.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff     <= store_mem[rd_addr];
         fwd_hit_ff  <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

   // A write that collided with the read supplies the newer entry.
   assign rd_data = fwd_hit_ff ? fwd_data_ff : rd_q_ff;

endmodule

### hw/rtl/lap3_window.sv
// ----------------------------------------------------------------------------
// lap3_window: 3x3 window and Laplacian arithmetic
// Shifts one column per pixel into the window, then forms the row sums and
// the final neighbour sum minus eight times the centre over two stages.
// ----------------------------------------------------------------------------
module lap3_window #(
   parameter int XW = $clog2(lap3_pkg::MAX_WIDTH_DEF)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic                                  in_emit,
   input  logic [lap3_pkg::PIXEL_W-1:0]          in_pixel,
   input  logic [2*lap3_pkg::PIXEL_W-1:0]        in_store,
   input  logic [XW-1:0]                         in_centre_x,
   input  lap3_pkg::pos_type                     in_pos,
   output logic                                  out_valid,
   output logic signed [lap3_pkg::EDGE_W-1:0]    out_edge_value,
   output logic [XW-1:0]                         out_centre_x,
   output lap3_pkg::pos_type                     out_pos,
   output logic [1:0]                            inflight
);
   import lap3_pkg::*;

   localparam int ROW3_W = PIXEL_W + 2;
   localparam int ROW2_W = PIXEL_W + 1;
   localparam int NB_W   = PIXEL_W + 3;

   logic [PIXEL_W-1:0] win_ff [9];

   logic               s2_valid_ff;
   logic [XW-1:0]      s2_centre_x_ff;
   pos_type            s2_pos_ff;

   logic               s3_valid_ff;
   logic [XW-1:0]      s3_centre_x_ff;
   pos_type            s3_pos_ff;
   logic [ROW3_W-1:0]  top_sum_ff;
   logic [ROW2_W-1:0]  side_sum_ff;
   logic [ROW3_W-1:0]  bot_sum_ff;
   logic [PIXEL_W-1:0] centre_ff;

   logic [NB_W-1:0]    neighbour_sum;

   // Window shift: the new column is upper store, middle store, incoming pixel.
   always_ff @(posedge clock) begin
      if (in_valid) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k*3]     <= win_ff[k*3+1];
            win_ff[k*3 + 1] <= win_ff[k*3+2];
         end
         win_ff[2] <= in_store[2*PIXEL_W-1:PIXEL_W];
         win_ff[5] <= in_store[PIXEL_W-1:0];
         win_ff[8] <= in_pixel;
      end
   end

   // Stage valid bits; only items that produce a result go on.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= in_valid && in_emit;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Position is registered alongside the window shift.
   always_ff @(posedge clock) begin
      if (in_valid) begin
         s2_centre_x_ff <= in_centre_x;
         s2_pos_ff      <= in_pos;
      end
   end

   // Row sums of the finished window.
   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         top_sum_ff     <= ROW3_W'(win_ff[0]) + ROW3_W'(win_ff[1]) + ROW3_W'(win_ff[2]);
         side_sum_ff    <= ROW2_W'(win_ff[3]) + ROW2_W'(win_ff[5]);
         bot_sum_ff     <= ROW3_W'(win_ff[6]) + ROW3_W'(win_ff[7]) + ROW3_W'(win_ff[8]);
         centre_ff      <= win_ff[4];
         s3_centre_x_ff <= s2_centre_x_ff;
         s3_pos_ff      <= s2_pos_ff;
      end
   end

   // Neighbour sum minus eight times the centre; the queue registers it.
   assign neighbour_sum  = NB_W'(top_sum_ff) + NB_W'(side_sum_ff) + NB_W'(bot_sum_ff);
   assign out_edge_value = $signed({1'b0, neighbour_sum}) - $signed({1'b0, centre_ff, 3'b000});
   assign out_valid      = s3_valid_ff;
   assign out_centre_x   = s3_centre_x_ff;
   assign out_pos        = s3_pos_ff;
   assign inflight       = {1'b0, s2_valid_ff} + {1'b0, s3_valid_ff};

endmodule

### hw/rtl/lap3_out_fifo.sv
// ----------------------------------------------------------------------------
// lap3_out_fifo: result queue of the 3x3 Laplacian filter
// Holds finished result items until the consumer takes them, so that the
// pipeline keeps moving while the output stalls.
// ----------------------------------------------------------------------------
module lap3_out_fifo #(
   parameter int XW    = $clog2(lap3_pkg::MAX_WIDTH_DEF),
   parameter int DEPTH = lap3_pkg::OUT_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push_valid,
   input  logic signed [lap3_pkg::EDGE_W-1:0]  push_edge_value,
   input  logic [XW-1:0]                       push_centre_x,
   input  lap3_pkg::pos_type                   push_pos,
   output logic                                pop_valid,
   input  logic                                pop_ready,
   output logic signed [lap3_pkg::EDGE_W-1:0]  pop_edge_value,
   output logic [XW-1:0]                       pop_centre_x,
   output lap3_pkg::pos_type                   pop_pos,
   output logic [$clog2(DEPTH+1)-1:0]          count
);
   import lap3_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic signed [EDGE_W-1:0] edge_q_ff [DEPTH];
   logic [XW-1:0]            x_q_ff    [DEPTH];
   pos_type                  pos_q_ff  [DEPTH];

   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff,  count_in;
   logic          pop;

   assign pop = pop_valid && pop_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (32'(wr_ptr_ff) == DEPTH - 1) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == DEPTH - 1) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push_valid && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push_valid) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push_valid) begin
         edge_q_ff[wr_ptr_ff] <= push_edge_value;
         x_q_ff[wr_ptr_ff]    <= push_centre_x;
         pos_q_ff[wr_ptr_ff]  <= push_pos;
      end
   end

   assign pop_valid      = (count_ff != '0);
   assign pop_edge_value = edge_q_ff[rd_ptr_ff];
   assign pop_centre_x   = x_q_ff[rd_ptr_ff];
   assign pop_pos        = pos_q_ff[rd_ptr_ff];
   assign count          = count_ff;

   // The credit check upstream must never let the queue overflow.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (32'(count_ff) == DEPTH) |-> !push_valid)
      else $error("result queue pushed while full");

endmodule

### hw/rtl/laplacian_3x3_filter.sv
// ----------------------------------------------------------------------------
// laplacian_3x3_filter: 8-neighbour Laplacian over a raster pixel stream
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_valid/req_ready    req_pixel
//   rsp_     out        rsp_valid/rsp_ready    rsp_edge_value, rsp_centre_x,
//                                              rsp_centre_y, rsp_frame_last
//   csr_     in         csr_write_enable       csr_index, csr_write_data
//
// One pixel is accepted per cycle while req_ready is high; each pixel costs one read
// and one write of the line store memory on separate ports, the write in the cycle
// after the read. A result passes stages s1, s2, s3 and the queue before it is offered.
// The result queue holds eight items; req_ready falls when the items in the
// pipeline that will produce results plus the queued ones reach eight.
// Reset clears counters and registers at once; there is no clearing pass,
// as the line stores are read only after the frame has written them.
// ----------------------------------------------------------------------------
module laplacian_3x3_filter #(
   parameter int MAX_WIDTH = lap3_pkg::MAX_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [lap3_pkg::PIXEL_W-1:0]         req_pixel,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [lap3_pkg::EDGE_W-1:0]   rsp_edge_value,
   output logic [$clog2(MAX_WIDTH)-1:0]         rsp_centre_x,
   output logic [lap3_pkg::ROW_W-1:0]           rsp_centre_y,
   output logic                                 rsp_frame_last,
   input  logic                                 csr_write_enable,
   input  logic [lap3_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lap3_pkg::CSR_DATA_W-1:0]      csr_write_data
);
   import lap3_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int WW = XW + 1;
   localparam int CW = $clog2(OUT_DEPTH + 1);
   localparam int PW = CW + 1;

   // Configuration registers.
   logic [IMG_W_W-1:0] image_width_ff;
   logic [IMG_H_W-1:0] image_height_ff;
   logic [WW-1:0]      eff_width;
   logic [IMG_H_W-1:0] eff_height;
   logic               csr_known;

   // Raster position of the next pixel.
   logic [XW-1:0]      column_count_ff, column_count_in;
   logic [ROW_W-1:0]   row_count_ff,    row_count_in;
   logic [WW-1:0]      col_next;

   // Stage after accept, waiting for the line store read.
   logic               s1_valid_ff;
   logic               s1_emit_ff;
   logic [PIXEL_W-1:0] s1_pixel_ff;
   logic [XW-1:0]      s1_col_ff;
   logic [XW-1:0]      s1_centre_x_ff;
   pos_type            s1_pos_ff;

   logic                    req_accept;
   logic                    item_emit;
   logic                    item_last;
   logic [2*PIXEL_W-1:0]    store_rd;
   logic                    win_valid;
   logic signed [EDGE_W-1:0] win_edge_value;
   logic [XW-1:0]           win_centre_x;
   pos_type                 win_pos;
   logic [1:0]              win_inflight;
   logic [CW-1:0]           fifo_count;
   pos_type                 rsp_pos;
   logic [PW-1:0]           pending;

   // Effective image size, clamped to the supported range.
   always_comb begin
      if (32'(image_width_ff) < MIN_SIZE) begin
         eff_width = WW'(MIN_SIZE);
      end else if (32'(image_width_ff) > MAX_WIDTH) begin
         eff_width = WW'(MAX_WIDTH);
      end else begin
         eff_width = WW'(image_width_ff);
      end
      if (32'(image_height_ff) < MIN_SIZE) begin
         eff_height = IMG_H_W'(MIN_SIZE);
      end else begin
         eff_height = image_height_ff;
      end
   end

   assign csr_known = (csr_index == CSR_IMAGE_WIDTH) || (csr_index == CSR_IMAGE_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_RESET;
         image_height_ff <= HEIGHT_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_IMAGE_WIDTH) begin
            image_width_ff <= csr_write_data[IMG_W_W-1:0];
         end
         if (csr_index == CSR_IMAGE_HEIGHT) begin
            image_height_ff <= csr_write_data[IMG_H_W-1:0];
         end
      end
   end

   // Credit: items that will give a result plus queued results stay within the queue size.
   assign pending   = PW'(s1_emit_ff && s1_valid_ff) + PW'(win_inflight) + PW'(fifo_count);
   assign req_ready = (pending < PW'(OUT_DEPTH));
   assign req_accept = req_valid && req_ready;

   // Interior test and end-of-frame mark of the incoming pixel.
   assign item_emit = (column_count_ff >= XW'(2)) && (row_count_ff >= ROW_W'(2));
   assign item_last = ({1'b0, column_count_ff} == eff_width - WW'(1))
                   && (row_count_ff == eff_height - IMG_H_W'(1));

   // Raster counters; a register write restarts the frame.
   assign col_next = {1'b0, column_count_ff} + WW'(1);

   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (csr_write_enable && csr_known) begin
         column_count_in = '0;
         row_count_in    = '0;
      end else if (req_accept) begin
         if (col_next >= eff_width) begin
            column_count_in = '0;
            if (row_count_ff == eff_height - IMG_H_W'(1)) begin
               row_count_in = '0;
            end else begin
               row_count_in = row_count_ff + ROW_W'(1);
            end
         end else begin
            column_count_in = col_next[XW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
         s1_valid_ff     <= 1'b0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         s1_valid_ff     <= req_accept;
      end
   end

   // Accepted item waits here while its line store entry is read.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_emit_ff         <= item_emit;
         s1_pixel_ff        <= req_pixel;
         s1_col_ff          <= column_count_ff;
         s1_centre_x_ff     <= column_count_ff - XW'(1);
         s1_pos_ff.last     <= item_last;
         s1_pos_ff.centre_y <= row_count_ff - ROW_W'(1);
      end
   end

   // Line stores: read at accept, written back with the rows moved up.
   lap3_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (column_count_ff),
      .rd_data (store_rd),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data ({store_rd[PIXEL_W-1:0], s1_pixel_ff})
   );

   lap3_window #(
      .XW (XW)
   ) u_window (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (s1_valid_ff),
      .in_emit        (s1_emit_ff),
      .in_pixel       (s1_pixel_ff),
      .in_store       (store_rd),
      .in_centre_x    (s1_centre_x_ff),
      .in_pos         (s1_pos_ff),
      .out_valid      (win_valid),
      .out_edge_value (win_edge_value),
      .out_centre_x   (win_centre_x),
      .out_pos        (win_pos),
      .inflight       (win_inflight)
   );

   lap3_out_fifo #(
      .XW    (XW),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock           (clock),
      .reset           (reset),
      .push_valid      (win_valid),
      .push_edge_value (win_edge_value),
      .push_centre_x   (win_centre_x),
      .push_pos        (win_pos),
      .pop_valid       (rsp_valid),
      .pop_ready       (rsp_ready),
      .pop_edge_value  (rsp_edge_value),
      .pop_centre_x    (rsp_centre_x),
      .pop_pos         (rsp_pos),
      .count           (fifo_count)
   );

   assign rsp_centre_y   = rsp_pos.centre_y;
   assign rsp_frame_last = rsp_pos.last;

   // Outstanding results never exceed the queue size.
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      pending <= PW'(OUT_DEPTH))
      else $error("more results outstanding than queue entries");

   // An accepted pixel always lies inside the active row.
   a_column_in_row: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> ({1'b0, column_count_ff} < eff_width))
      else $error("column counter outside the active width");

   // A register write restarts the frame.
   a_csr_restart: assert property (@(posedge clock) disable iff (reset)
      (csr_write_enable && csr_known) |=> (column_count_ff == '0 && row_count_ff == '0))
      else $error("register write did not restart the frame");

endmodule
